// File: rtl/core/pgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgc_pkg: shared types and constants for the polygon gate crossing test
// Coordinate, difference and product types, the opcode enum and the item
// record that travels down the cell chain.
// ----------------------------------------------------------------------------
package pgc_pkg;

	localparam int COORD_BITS       = 32;
	localparam int DIFF_BITS        = COORD_BITS + 1;
	localparam int PROD_BITS        = 2 * DIFF_BITS;
	localparam int SLOT_BITS        = 4;
	localparam int CNT_CFG_BITS     = 5;
	localparam int MAX_VERTICES_DEF = 16;
	localparam int COUNT_RESET      = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_CLASSIFY = 1'b1
	} opcode_t;

	// one item in flight; vertex fields are picked up along the chain
	typedef struct packed {
		opcode_t              op;
		logic [SLOT_BITS-1:0] slot;
		coord_t               px;
		coord_t               py;
		logic                 mark;
		logic                 parity;
		coord_t               prev_x;
		coord_t               prev_y;
		coord_t               first_x;
		coord_t               first_y;
		coord_t               last_x;
		coord_t               last_y;
	} item_t;

	// control into an edge test unit
	typedef struct packed {
		logic adv;
		logic test_en;
	} edge_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/pgc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgc_ifs: valid/ready channels of the polygon gate crossing test
// Item input, result output and vertex count configuration channels.
// ----------------------------------------------------------------------------
interface pgc_in_if import pgc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [SLOT_BITS-1:0] vertex_slot;
	coord_t               coord_x;
	coord_t               coord_y;
	logic                 already_gated;

	modport source (output valid, output opcode, output vertex_slot, output coord_x,
		output coord_y, output already_gated, input ready);
	modport sink (input valid, input opcode, input vertex_slot, input coord_x,
		input coord_y, input already_gated, output ready);
endinterface

interface pgc_out_if ();
	logic valid;
	logic ready;
	logic inside_res;
	logic gated;

	modport source (output valid, output inside_res, output gated, input ready);
	modport sink (input valid, input inside_res, input gated, output ready);
endinterface

interface pgc_cfg_if import pgc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CNT_CFG_BITS-1:0] vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pgc_edge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgc_edge: crossing test of one polygon edge against one point
// Stage 1 forms differences and span checks, stage 2 the two cross
// products; the exact compare leaves as a combinational hit.
// ----------------------------------------------------------------------------
module pgc_edge import pgc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire edge_ctl_t ctl,
	input  wire coord_t    x1,
	input  wire coord_t    y1,
	input  wire coord_t    x2,
	input  wire coord_t    y2,
	input  wire coord_t    px,
	input  wire coord_t    py,
	output logic           hit
);

	diff_t dx, dy, da, dc;
	logic  cond;

	logic  pre_s1, pre_s2;
	logic  vert_s1, vert_s2;
	diff_t m0a_s1, m0b_s1, m1a_s1, m1b_s1;
	prod_t p0_s2, p1_s2;

	always_comb begin
		dx = diff_t'(x2) - diff_t'(x1);
		dy = diff_t'(y2) - diff_t'(y1);
		da = diff_t'(px) - diff_t'(x1);
		dc = diff_t'(py) - diff_t'(y1);
		// half-open y span, x at most the larger end, not horizontal
		cond = ((py > y1) || (py > y2)) && ((py <= y1) || (py <= y2)) &&
			((px <= x1) || (px <= x2)) && (dy != diff_t'(0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1 <= 1'b0;
			pre_s2 <= 1'b0;
		end else if (ctl.adv) begin
			pre_s1 <= ctl.test_en && cond;
			pre_s2 <= pre_s1;
		end
	end

	// compare order flips with the sign of dy so no division is needed
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			vert_s1 <= (dx == diff_t'(0));
			if (dy > diff_t'(0)) begin
				m0a_s1 <= da;
				m0b_s1 <= dy;
				m1a_s1 <= dc;
				m1b_s1 <= dx;
			end else begin
				m0a_s1 <= dc;
				m0b_s1 <= dx;
				m1a_s1 <= da;
				m1b_s1 <= dy;
			end
			vert_s2 <= vert_s1;
			p0_s2   <= m0a_s1 * m0b_s1;
			p1_s2   <= m1a_s1 * m1b_s1;
		end
	end

	assign hit = pre_s2 && (vert_s2 || (p0_s2 <= p1_s2));

endmodule
`default_nettype wire

// File: rtl/core/pgc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgc_cell: one vertex cell of the chain
// Holds one vertex, tests the edge from the previous vertex to its own,
// and hands the item on after three stages with its vertex attached.
// ----------------------------------------------------------------------------
module pgc_cell import pgc_pkg::*; #(
	parameter int CELL_INDEX = 0,
	parameter int CNT_W      = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [CNT_W-1:0] n_used,
	input  wire logic             in_v,
	input  wire item_t            in_it,
	output logic                  out_v,
	output item_t                 out_it
);

	localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_INDEX);
	localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_INDEX + 1);

	coord_t    own_x_q, own_y_q;
	logic      wr_hit;
	item_t     nxt, fin;
	edge_ctl_t ctl;
	logic      hit;

	logic      v_s1, v_s2, out_v_q;
	item_t     it_s1, it_s2, out_q;

	assign wr_hit = (int'(in_it.slot) == CELL_INDEX);

	// cell 0 has no edge of its own; the closing edge is tested after the chain
	assign ctl.adv     = adv;
	assign ctl.test_en = in_v && (in_it.op == OP_CLASSIFY) && (CELL_INDEX != 0) &&
		(MY_IDX < n_used);

	pgc_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.x1     (in_it.prev_x),
		.y1     (in_it.prev_y),
		.x2     (own_x_q),
		.y2     (own_y_q),
		.px     (in_it.px),
		.py     (in_it.py),
		.hit    (hit)
	);

	always_comb begin
		nxt        = in_it;
		nxt.prev_x = own_x_q;
		nxt.prev_y = own_y_q;
		if (CELL_INDEX == 0) begin
			nxt.first_x = own_x_q;
			nxt.first_y = own_y_q;
		end
		if (MY_NEXT == n_used) begin
			nxt.last_x = own_x_q;
			nxt.last_y = own_y_q;
		end
	end

	always_comb begin
		fin        = it_s2;
		fin.parity = it_s2.parity ^ hit;
	end

	always_ff @(posedge clk) begin
		if (adv && in_v && (in_it.op == OP_LOAD) && wr_hit) begin
			own_x_q <= in_it.px;
			own_y_q <= in_it.py;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_v;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= nxt;
			it_s2 <= it_s1;
			out_q <= fin;
		end
	end

	assign out_v  = out_v_q;
	assign out_it = out_q;

endmodule
`default_nettype wire

// File: rtl/core/polygon_gate_crossing_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_gate_crossing_test: point in polygon gate by crossing parity
// Chain of vertex cells followed by a closing edge test and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   items   : valid/ready input. opcode 0 loads coord_x/coord_y into vertex
//             vertex_slot; opcode 1 classifies the point coord_x/coord_y.
//   results : valid/ready output, one transfer per classify, none per load:
//             inside_res (odd crossing count) and gated (already_gated or it).
//   cfg     : vertex_count write channel, always ready; write it only while
//             no item is in flight. Counts above MAX_VERTICES saturate.
//   Rate    : one item per cycle while results is not stalled; every cell
//             and the closing edge unit move their stages in lock step,
//             three stages per cell.
//   Loads travel down the chain with the classify items, so a load takes
//   effect for exactly the items that follow it.
//   Reset   : clears all valid flags and sets vertex_count to 3; vertex
//             storage holds no defined value until loaded.
//   Stall   : while results is valid and not ready the whole chain holds
//             and items.ready is low.
// ----------------------------------------------------------------------------
module polygon_gate_crossing_test import pgc_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pgc_cfg_if.sink  cfg,
	pgc_in_if.sink   items,
	pgc_out_if.source results
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int SAT_W = (CNT_W > CNT_CFG_BITS) ? CNT_W : CNT_CFG_BITS;

	logic [CNT_CFG_BITS-1:0] count_q;
	logic [CNT_W-1:0]        n_eff;
	logic                    adv;

	logic      ch_v  [MAX_VERTICES+1];
	item_t     ch_it [MAX_VERTICES+1];
	item_t     in_it;

	edge_ctl_t close_ctl;
	logic      close_hit;
	logic      v_c1, v_c2;
	item_t     it_c1, it_c2;
	logic      fin_parity;

	logic      out_valid_q, inside_q, gated_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_CFG_BITS'(COUNT_RESET);
		end else if (cfg.valid) begin
			count_q <= cfg.vertex_count;
		end
	end

	always_comb begin
		if (SAT_W'(count_q) > SAT_W'(MAX_VERTICES)) begin
			n_eff = CNT_W'(MAX_VERTICES);
		end else begin
			n_eff = CNT_W'(count_q);
		end
	end

	assign adv         = !out_valid_q || results.ready;
	assign items.ready = adv;

	always_comb begin
		in_it         = '0;
		in_it.op      = opcode_t'(items.opcode);
		in_it.slot    = items.vertex_slot;
		in_it.px      = items.coord_x;
		in_it.py      = items.coord_y;
		in_it.mark    = items.already_gated;
		in_it.parity  = 1'b0;
	end

	assign ch_v[0]  = items.valid;
	assign ch_it[0] = in_it;

	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
		pgc_cell #(
			.CELL_INDEX (g),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.n_used (n_eff),
			.in_v   (ch_v[g]),
			.in_it  (ch_it[g]),
			.out_v  (ch_v[g+1]),
			.out_it (ch_it[g+1])
		);
	end

	// closing edge: last vertex in use back to the first
	assign close_ctl.adv     = adv;
	assign close_ctl.test_en = ch_v[MAX_VERTICES] &&
		(ch_it[MAX_VERTICES].op == OP_CLASSIFY) && (n_eff != '0);

	pgc_edge u_close (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (close_ctl),
		.x1     (ch_it[MAX_VERTICES].last_x),
		.y1     (ch_it[MAX_VERTICES].last_y),
		.x2     (ch_it[MAX_VERTICES].first_x),
		.y2     (ch_it[MAX_VERTICES].first_y),
		.px     (ch_it[MAX_VERTICES].px),
		.py     (ch_it[MAX_VERTICES].py),
		.hit    (close_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1        <= 1'b0;
			v_c2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_c1        <= ch_v[MAX_VERTICES];
			v_c2        <= v_c1;
			out_valid_q <= v_c2 && (it_c2.op == OP_CLASSIFY);
		end
	end

	assign fin_parity = it_c2.parity ^ close_hit;

	always_ff @(posedge clk) begin
		if (adv) begin
			it_c1    <= ch_it[MAX_VERTICES];
			it_c2    <= it_c1;
			inside_q <= fin_parity;
			gated_q  <= it_c2.mark | fin_parity;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.inside_res = inside_q;
	assign results.gated      = gated_q;

	// a new result only comes from a classify item in the last closing stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_c2 && (it_c2.op == OP_CLASSIFY)))
		else $error("result appeared without a classify item behind it");

	// a stalled result freezes the closing stages
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> ($stable(v_c2) && (!v_c2 || $stable(it_c2.parity))))
		else $error("chain moved while the result was stalled");

	// with no edges in use nothing can be inside
	a_empty_polygon: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (n_eff == '0)) |-> !inside_q)
		else $error("inside reported for an empty polygon");

endmodule
`default_nettype wire

// File: tb/sv/tb_polygon_gate_crossing_test.sv
// ----------------------------------------------------------------------------
// tb_polygon_gate_crossing_test: self-checking bench for the polygon gate
// Loads polygon vertices, classifies points against them and compares every
// result transfer with a typed table value or an in-bench crossing-parity
// predictor. A directed table covers the corner cases, then random polygons
// and points run under several vertex counts and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_polygon_gate_crossing_test;
	import pgc_pkg::*;

	localparam int LATENCY     = 3 * MAX_VERTICES_DEF + 2;
	localparam int DRAIN       = LATENCY + 8;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 36;
	localparam int NUM_PHASES  = 12;
	localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	typedef struct {
		logic in_poly;
		logic gated;
	} gate_res_t;

	typedef enum {ROW_LOAD, ROW_CLASSIFY, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t               kind;
		logic [SLOT_BITS-1:0]    slot;
		coord_t                  x;
		coord_t                  y;
		logic                    mark;
		bit                      typed;
		logic                    in_poly;
		logic [CNT_CFG_BITS-1:0] count;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pgc_in_if  item_ch ();
	pgc_out_if result_ch ();
	pgc_cfg_if cfg_ch ();

	polygon_gate_crossing_test dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (item_ch),
		.results (result_ch)
	);

	// bench copy of the block state
	coord_t                  poly_x [MAX_VERTICES_DEF];
	coord_t                  poly_y [MAX_VERTICES_DEF];
	logic [CNT_CFG_BITS-1:0] poly_count;

	gate_res_t expected_gate_q [$];
	int        mismatch_count = 0;
	int        quiet_cycles   = 0;
	int        src_pct        = 0;
	int        sink_pct       = 0;

	int phase_counts [NUM_PHASES] = '{4, 16, 31, 3, 7, 1, 12, 0, 16, 5, 31, 2};

	// triangle (0,0) (16,0) (0,16) in Q24.8, then a full-range triangle
	stim_row_t directed_rows [23] = '{
		'{ROW_LOAD,     4'd0, 32'sd0,     32'sd0,     1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_LOAD,     4'd1, 32'sd4096,  32'sd0,     1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_LOAD,     4'd2, 32'sd0,     32'sd4096,  1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd256,   32'sd256,   1'b0, 1'b1, 1'b1, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd8192,  32'sd8192,  1'b0, 1'b1, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd9, 32'sd8192,  32'sd8192,  1'b1, 1'b1, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, CMIN,       CMIN,       1'b1, 1'b1, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'hf, CMAX,       CMAX,       1'b0, 1'b1, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd0,     32'sd0,     1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd2048,  32'sd2048,  1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd0,     32'sd2048,  1'b1, 1'b0, 1'b0, 5'd0},
		'{ROW_LOAD,     4'd0, CMIN,       CMIN,       1'b1, 1'b0, 1'b0, 5'd0},
		'{ROW_LOAD,     4'd1, CMAX,       CMIN,       1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_LOAD,     4'd2, CMIN,       CMAX,       1'b1, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd0,     32'sd0,     1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, CMAX,       CMAX,       1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, CMIN,       -32'sd1,    1'b1, 1'b0, 1'b0, 5'd0},
		'{ROW_COUNT,    4'd0, 32'sd0,     32'sd0,     1'b0, 1'b0, 1'b0, 5'd0},
		'{ROW_CLASSIFY, 4'd0, 32'sd0,     32'sd0,     1'b1, 1'b1, 1'b0, 5'd0},
		'{ROW_COUNT,    4'd0, 32'sd0,     32'sd0,     1'b0, 1'b0, 1'b0, 5'd1},
		'{ROW_CLASSIFY, 4'd0, CMIN,       CMAX,       1'b0, 1'b1, 1'b0, 5'd0},
		'{ROW_COUNT,    4'd0, 32'sd0,     32'sd0,     1'b0, 1'b0, 1'b0, 5'd3},
		'{ROW_CLASSIFY, 4'd0, -32'sd1,    32'sd0,     1'b0, 1'b0, 1'b0, 5'd0}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit coin(int pct);
		return $urandom_range(99) < pct;
	endfunction

	// exact crossing test; products of 33-bit differences fit in 68 bits
	function automatic bit edge_crossed(coord_t x1, coord_t y1, coord_t x2, coord_t y2,
		coord_t px, coord_t py);
		longint lx1, ly1, lx2, ly2, lpx, lpy;
		longint ylo, yhi, xhi, dx, dy;
		logic signed [67:0] a, b, c, d;
		lx1 = longint'(x1);
		ly1 = longint'(y1);
		lx2 = longint'(x2);
		ly2 = longint'(y2);
		lpx = longint'(px);
		lpy = longint'(py);
		ylo = (ly1 < ly2) ? ly1 : ly2;
		yhi = (ly1 < ly2) ? ly2 : ly1;
		xhi = (lx1 < lx2) ? lx2 : lx1;
		dx  = lx2 - lx1;
		dy  = ly2 - ly1;
		if (!(lpy > ylo && lpy <= yhi && lpx <= xhi && dy != 0))
			return 1'b0;
		if (dx == 0)
			return 1'b1;
		if (dy > 0) begin
			a = 68'(lpx - lx1);
			b = 68'(dy);
			c = 68'(lpy - ly1);
			d = 68'(dx);
		end else begin
			a = 68'(lpy - ly1);
			b = 68'(dx);
			c = 68'(lpx - lx1);
			d = 68'(dy);
		end
		return (a * b) <= (c * d);
	endfunction

	function automatic logic point_inside(coord_t px, coord_t py);
		int   n;
		int   j;
		logic parity;
		n      = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(poly_count);
		parity = 1'b0;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			parity ^= edge_crossed(poly_x[i], poly_y[i], poly_x[j], poly_y[j], px, py);
		end
		return parity;
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(3))
			0: return CMIN;
			1: return CMAX;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	function automatic coord_t rand_coord(int scale);
		case (scale)
			0: return $signed($urandom_range(32767)) - 16384;
			1: return $signed($urandom_range(33554431)) - 16777216;
			default: return coord_t'($urandom);
		endcase
	endfunction

	// points by vertex x/y, on edge midpoints, in the polygon's range, or anywhere
	function automatic void make_point(int ne, int scale, output coord_t px, output coord_t py);
		int     r, i, j;
		longint sx, sy;
		r = $urandom_range(99);
		if (ne == 0 || r >= 85) begin
			px = coord_t'($urandom);
			py = coord_t'($urandom);
			if ($urandom_range(3) == 0)
				px = pick_extreme();
			if ($urandom_range(3) == 0)
				py = pick_extreme();
		end else if (r < 30) begin
			i  = $urandom_range(ne - 1);
			j  = $urandom_range(ne - 1);
			px = poly_x[i] + ($signed($urandom_range(4)) - 2);
			py = poly_y[j] + ($signed($urandom_range(4)) - 2);
		end else if (r < 45) begin
			i  = $urandom_range(ne - 1);
			j  = (i + 1 == ne) ? 0 : i + 1;
			sx = longint'(poly_x[i]);
			sy = longint'(poly_y[i]);
			sx = (sx + longint'(poly_x[j])) >>> 1;
			sy = (sy + longint'(poly_y[j])) >>> 1;
			px = coord_t'(sx);
			py = coord_t'(sy);
		end else begin
			px = rand_coord(scale);
			py = rand_coord(scale);
		end
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 100)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic set_idle(int mode);
		case (mode)
			0: begin src_pct = 0;  sink_pct = 0;  end
			1: begin src_pct = 86; sink_pct = 0;  end
			2: begin src_pct = 0;  sink_pct = 86; end
			default: begin src_pct = 13; sink_pct = 13; end
		endcase
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic push_item(opcode_t op, logic [SLOT_BITS-1:0] slot, coord_t x, coord_t y,
		logic mark, bit typed, logic typed_inside);
		gate_res_t res;
		while (coin(src_pct)) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid         = 1'b1;
		item_ch.opcode        = op;
		item_ch.vertex_slot   = slot;
		item_ch.coord_x       = x;
		item_ch.coord_y       = y;
		item_ch.already_gated = mark;
		do
			@(posedge clk);
		while (!item_ch.ready);
		if (op == OP_LOAD) begin
			poly_x[slot] = x;
			poly_y[slot] = y;
		end else begin
			res.in_poly = typed ? typed_inside : point_inside(x, y);
			res.gated   = res.in_poly | mark;
			expected_gate_q.insert(expected_gate_q.size(), res);
		end
		@(negedge clk);
	endtask

	// loads leave nothing to wait for, so pause a full pipeline depth as well
	task automatic write_vertex_count(logic [CNT_CFG_BITS-1:0] n);
		item_ch.valid = 1'b0;
		while (expected_gate_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_ch.valid        = 1'b1;
		cfg_ch.vertex_count = n;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		poly_count = n;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	always @(negedge clk)
		result_ch.ready = !coin(sink_pct);

	always @(posedge clk) begin
		gate_res_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_gate_q.size() == 0) begin
				report_mismatch("result transfer with nothing outstanding");
			end else begin
				want = expected_gate_q.pop_front();
				if (result_ch.inside_res !== want.in_poly)
					report_mismatch($sformatf("inside_res %b, want %b",
						result_ch.inside_res, want.in_poly));
				if (result_ch.gated !== want.gated)
					report_mismatch($sformatf("gated %b, want %b",
						result_ch.gated, want.gated));
			end
		end
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int     ne, scale;
		coord_t px, py;
		item_ch.valid         = 1'b0;
		item_ch.opcode        = OP_LOAD;
		item_ch.vertex_slot   = '0;
		item_ch.coord_x       = '0;
		item_ch.coord_y       = '0;
		item_ch.already_gated = 1'b0;
		result_ch.ready       = 1'b1;
		cfg_ch.valid          = 1'b0;
		cfg_ch.vertex_count   = '0;
		poly_count            = CNT_CFG_BITS'(COUNT_RESET);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_idle(0);
		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_COUNT: write_vertex_count(directed_rows[i].count);
				ROW_LOAD: push_item(OP_LOAD, directed_rows[i].slot, directed_rows[i].x,
					directed_rows[i].y, directed_rows[i].mark, 1'b0, 1'b0);
				default: push_item(OP_CLASSIFY, directed_rows[i].slot, directed_rows[i].x,
					directed_rows[i].y, directed_rows[i].mark, directed_rows[i].typed,
					directed_rows[i].in_poly);
			endcase
		end

		// each phase: new count, fresh polygon in the live slots, then mostly points
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_idle(p % 4);
			write_vertex_count(CNT_CFG_BITS'(phase_counts[p]));
			ne    = (phase_counts[p] > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : phase_counts[p];
			scale = $urandom_range(99);
			scale = (scale < 60) ? 0 : (scale < 85) ? 1 : 2;
			for (int s = 0; s < ne; s++) begin
				px = ($urandom_range(19) == 0) ? pick_extreme() : rand_coord(scale);
				py = ($urandom_range(19) == 0) ? pick_extreme() : rand_coord(scale);
				push_item(OP_LOAD, SLOT_BITS'(s), px, py, 1'($urandom_range(1)), 1'b0, 1'b0);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 8) begin
					// stray vertex write, may bend the live polygon
					push_item(OP_LOAD, SLOT_BITS'($urandom_range(15)), rand_coord(scale),
						rand_coord(scale), 1'($urandom_range(1)), 1'b0, 1'b0);
				end else begin
					make_point(ne, scale, px, py);
					push_item(OP_CLASSIFY, SLOT_BITS'($urandom_range(15)), px, py,
						1'($urandom_range(1)), 1'b0, 1'b0);
				end
			end
		end

		item_ch.valid = 1'b0;
		while (expected_gate_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
